>>> rtl/edfts_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the EDF task table scheduler.
// Depends on nothing; used by the controller, the datapath and the top level.
package edfts_pkg;

   localparam int TABLE_DEPTH_DEF = 64;

   localparam logic [7:0]  THRESHOLD_RESET = 8'd80;
   localparam logic [63:0] NO_DEADLINE     = 64'hFFFF_FFFF_FFFF_FFFF;

   // Request kinds.
   localparam logic [1:0] KIND_ADMIT = 2'd0;
   localparam logic [1:0] KIND_PICK  = 2'd1;
   localparam logic [1:0] KIND_BOOST = 2'd2;

   // Result status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_BELOW = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;
   localparam logic [1:0] ST_NONE  = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;     // capture the request word and reset the search
      logic scan_en;  // walk the table, one slot per cycle
      logic commit;   // update the table and load the response register
   } edfts_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;
   } edfts_stat_type;

endpackage

>>> rtl/edfts_ctrl.sv
`timescale 1ns / 1ps
// Controller of the EDF task table scheduler: request/response handshake and sequencing.
// Depends on edfts_pkg.
module edfts_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  edfts_pkg::edfts_stat_type stat,
   output edfts_pkg::edfts_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_COMMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The response register can take a new word when empty or being drained.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd.load    = (state_ff == S_IDLE) && req_valid;
      cmd.scan_en = (state_ff == S_SCAN);
      cmd.commit  = (state_ff == S_COMMIT) && out_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (stat.scan_done) state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.commit) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // A held response is never overwritten by the next commit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !cmd.commit)
      else $error("commit while response held");

   // Only the scan state may hand over to the commit state.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_COMMIT |-> $past(state_ff) == S_SCAN || $past(state_ff) == S_COMMIT)
      else $error("commit entered without a scan");

   // A request is taken only when no earlier request is in flight, and it starts a scan.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == S_SCAN)
      else $error("accepted request did not start a scan");

endmodule

>>> rtl/edfts_dp.sv
`timescale 1ns / 1ps
// Datapath of the EDF task table scheduler: task table memories, slot scan and updates.
// Depends on edfts_pkg.
module edfts_dp #(
   parameter int TABLE_DEPTH = edfts_pkg::TABLE_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  edfts_pkg::edfts_cmd_type  cmd,
   output edfts_pkg::edfts_stat_type stat,
   input  logic                      csr_wr_en,
   input  logic [7:0]                csr_wr_data,
   input  logic [1:0]                req_kind,
   input  logic [31:0]               req_pid,
   input  logic [31:0]               req_waiting_pid,
   input  logic [7:0]                req_task_priority,
   input  logic [63:0]               req_period,
   input  logic [63:0]               req_deadline,
   input  logic [63:0]               req_now,
   output logic [1:0]                rsp_status,
   output logic [31:0]               rsp_picked_pid,
   output logic                      rsp_deadline_missed,
   output logic                      rsp_boosted
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

   // Task table.
   logic [31:0] mem_pid [TABLE_DEPTH];
   logic [7:0]  mem_prio[TABLE_DEPTH];
   logic [63:0] mem_dl  [TABLE_DEPTH];
   logic [63:0] mem_per [TABLE_DEPTH];

   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [7:0]             thr_ff, thr_in;

   // Captured request word.
   logic [1:0]  kind_ff;
   logic [31:0] pid_ff, waiter_ff;
   logic [7:0]  prio_ff;
   logic [63:0] period_ff, deadline_ff, now_ff;

   // Scan pipeline.
   logic [CNT_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic             probe_live_ff, probe_live_in;
   logic [IDX_W-1:0] probe_idx_ff;
   logic             issue;
   logic [IDX_W-1:0] rd_addr;
   logic [31:0]      rd_pid_ff;
   logic [7:0]       rd_prio_ff;
   logic [63:0]      rd_dl_ff, rd_per_ff;
   logic             probe_ok;

   // Search results.
   logic             best_found_ff, best_found_in;
   logic [63:0]      best_dl_ff, best_dl_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic [31:0]      best_pid_ff, best_pid_in;
   logic [63:0]      best_per_ff, best_per_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic             w_found_ff, w_found_in;
   logic [7:0]       w_prio_ff, w_prio_in;
   logic             h_found_ff, h_found_in;
   logic [IDX_W-1:0] h_idx_ff, h_idx_in;
   logic [7:0]       h_prio_ff, h_prio_in;

   // Commit decisions.
   logic below, full, admit_ok, boost_ok, pick_free;
   logic do_admit, do_pick, do_boost;

   // Response register.
   logic [1:0]  status_ff, status_in;
   logic [31:0] out_pid_ff, out_pid_in;
   logic        missed_ff, missed_in;
   logic        boosted_ff, boosted_in;

   assign issue    = cmd.scan_en && (scan_cnt_ff != DEPTH_CNT);
   assign rd_addr  = scan_cnt_ff[IDX_W-1:0];
   assign probe_ok = probe_live_ff && valid_ff[probe_idx_ff];

   assign stat.scan_done = (scan_cnt_ff == DEPTH_CNT) && !probe_live_ff;

   always_comb begin
      scan_cnt_in   = scan_cnt_ff;
      probe_live_in = issue;
      best_found_in = best_found_ff;
      best_dl_in    = best_dl_ff;
      best_idx_in   = best_idx_ff;
      best_pid_in   = best_pid_ff;
      best_per_in   = best_per_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      w_found_in    = w_found_ff;
      w_prio_in     = w_prio_ff;
      h_found_in    = h_found_ff;
      h_idx_in      = h_idx_ff;
      h_prio_in     = h_prio_ff;
      if (cmd.load) begin
         scan_cnt_in   = '0;
         probe_live_in = 1'b0;
         best_found_in = 1'b0;
         best_dl_in    = edfts_pkg::NO_DEADLINE;
         free_found_in = 1'b0;
         w_found_in    = 1'b0;
         h_found_in    = 1'b0;
      end else begin
         if (issue) scan_cnt_in = scan_cnt_ff + CNT_W'(1);
         // The strict compare keeps ties at the lowest slot and never takes
         // a slot whose deadline is all ones.
         if (probe_ok && (rd_dl_ff < best_dl_ff)) begin
            best_found_in = 1'b1;
            best_dl_in    = rd_dl_ff;
            best_idx_in   = probe_idx_ff;
            best_pid_in   = rd_pid_ff;
            best_per_in   = rd_per_ff;
         end
         if (probe_live_ff && !valid_ff[probe_idx_ff] && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = probe_idx_ff;
         end
         if (probe_ok && (rd_pid_ff == waiter_ff) && !w_found_ff) begin
            w_found_in = 1'b1;
            w_prio_in  = rd_prio_ff;
         end
         if (probe_ok && (rd_pid_ff == pid_ff) && !h_found_ff) begin
            h_found_in = 1'b1;
            h_idx_in   = probe_idx_ff;
            h_prio_in  = rd_prio_ff;
         end
      end
   end

   always_comb begin
      below     = prio_ff < thr_ff;
      full      = !free_found_ff || (count_ff >= DEPTH_CNT);
      admit_ok  = !below && !full;
      boost_ok  = w_found_ff && h_found_ff && (w_prio_ff > h_prio_ff);
      pick_free = (best_per_ff == 64'd0);
      do_admit  = cmd.commit && (kind_ff == edfts_pkg::KIND_ADMIT) && admit_ok;
      do_pick   = cmd.commit && (kind_ff == edfts_pkg::KIND_PICK) && best_found_ff;
      do_boost  = cmd.commit && (kind_ff == edfts_pkg::KIND_BOOST) && boost_ok;
   end

   always_comb begin
      valid_in = valid_ff;
      count_in = count_ff;
      if (do_admit) begin
         valid_in[free_idx_ff] = 1'b1;
         count_in              = count_ff + CNT_W'(1);
      end
      if (do_pick && pick_free) begin
         valid_in[best_idx_ff] = 1'b0;
         if (count_ff != '0) count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      thr_in = thr_ff;
      if (csr_wr_en) thr_in = csr_wr_data;
   end

   always_comb begin
      status_in  = status_ff;
      out_pid_in = out_pid_ff;
      missed_in  = missed_ff;
      boosted_in = boosted_ff;
      if (cmd.commit) begin
         status_in  = edfts_pkg::ST_OK;
         out_pid_in = '0;
         missed_in  = 1'b0;
         boosted_in = 1'b0;
         case (kind_ff)
            edfts_pkg::KIND_ADMIT: begin
               if (below)     status_in = edfts_pkg::ST_BELOW;
               else if (full) status_in = edfts_pkg::ST_FULL;
            end
            edfts_pkg::KIND_PICK: begin
               if (best_found_ff) begin
                  out_pid_in = best_pid_ff;
                  missed_in  = now_ff > best_dl_ff;
               end else begin
                  status_in = edfts_pkg::ST_NONE;
               end
            end
            edfts_pkg::KIND_BOOST: begin
               boosted_in = boost_ok;
            end
            default: begin
               status_in = edfts_pkg::ST_OK;
            end
         endcase
      end
   end

   // Table memories: one read port for the scan, one write port for commits.
   always_ff @(posedge clock) begin
      if (issue) begin
         rd_pid_ff  <= mem_pid[rd_addr];
         rd_prio_ff <= mem_prio[rd_addr];
         rd_dl_ff   <= mem_dl[rd_addr];
         rd_per_ff  <= mem_per[rd_addr];
      end
      if (do_admit) begin
         mem_pid[free_idx_ff]  <= pid_ff;
         mem_per[free_idx_ff]  <= period_ff;
      end
      if (do_admit) begin
         mem_dl[free_idx_ff] <= deadline_ff;
      end else if (do_pick && !pick_free) begin
         mem_dl[best_idx_ff] <= best_dl_ff + best_per_ff;
      end
      if (do_admit) begin
         mem_prio[free_idx_ff] <= prio_ff;
      end else if (do_boost) begin
         mem_prio[h_idx_ff] <= w_prio_ff;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff     <= req_kind;
         pid_ff      <= req_pid;
         waiter_ff   <= req_waiting_pid;
         prio_ff     <= req_task_priority;
         period_ff   <= req_period;
         deadline_ff <= req_deadline;
         now_ff      <= req_now;
      end
      probe_idx_ff <= rd_addr;
      best_dl_ff   <= best_dl_in;
      best_idx_ff  <= best_idx_in;
      best_pid_ff  <= best_pid_in;
      best_per_ff  <= best_per_in;
      free_idx_ff  <= free_idx_in;
      w_prio_ff    <= w_prio_in;
      h_idx_ff     <= h_idx_in;
      h_prio_ff    <= h_prio_in;
      status_ff    <= status_in;
      out_pid_ff   <= out_pid_in;
      missed_ff    <= missed_in;
      boosted_ff   <= boosted_in;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         count_ff      <= '0;
         thr_ff        <= edfts_pkg::THRESHOLD_RESET;
         scan_cnt_ff   <= '0;
         probe_live_ff <= 1'b0;
         best_found_ff <= 1'b0;
         free_found_ff <= 1'b0;
         w_found_ff    <= 1'b0;
         h_found_ff    <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         count_ff      <= count_in;
         thr_ff        <= thr_in;
         scan_cnt_ff   <= scan_cnt_in;
         probe_live_ff <= probe_live_in;
         best_found_ff <= best_found_in;
         free_found_ff <= free_found_in;
         w_found_ff    <= w_found_in;
         h_found_ff    <= h_found_in;
      end
   end

   assign rsp_status          = status_ff;
   assign rsp_picked_pid      = out_pid_ff;
   assign rsp_deadline_missed = missed_ff;
   assign rsp_boosted         = boosted_ff;

   // The occupancy count always tracks the valid bits.
   assert property (@(posedge clock) disable iff (reset)
      count_ff == CNT_W'($countones(valid_ff)))
      else $error("occupancy count disagrees with valid bits");

   // A successful admit claims its slot.
   assert property (@(posedge clock) disable iff (reset)
      do_admit |=> valid_ff[$past(free_idx_ff)])
      else $error("admitted slot not valid");

   // Picking an aperiodic task frees its slot.
   assert property (@(posedge clock) disable iff (reset)
      do_pick && pick_free |=> !valid_ff[$past(best_idx_ff)])
      else $error("aperiodic task slot not freed");

   // The scan never runs past the end of the table.
   assert property (@(posedge clock) disable iff (reset)
      scan_cnt_ff <= DEPTH_CNT)
      else $error("scan counter out of range");

endmodule

>>> rtl/edf_task_table_scheduler.sv
`timescale 1ns / 1ps
// EDF task table scheduler, top level.
// Request words on the req_ channel (valid/ready) are one of: admit a task,
// pick the task with the earliest deadline, or boost a lock holder's priority
// to that of a waiter. Each request word yields exactly one response word on
// the rsp_ channel (valid/ready). The user must write the admit threshold through
// csr_wr_en / csr_wr_data only while idle; the block itself does not enforce it.
// Every request walks the whole task table, one slot per cycle through the
// single read port of the table memories, then commits; a new request is
// taken only once the previous one has committed and the block is idle again.
// Reset empties the table and sets the threshold to 80; it takes effect at
// once, with no clearing pass. A finished response sits in an output register,
// so the next request is taken while the receiver stalls; that request then
// waits in its commit step until the response register is drained.
// Depends on edfts_pkg, edfts_ctrl and edfts_dp.
module edf_task_table_scheduler #(
   parameter int TABLE_DEPTH = edfts_pkg::TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_pid,
   input  logic [31:0] req_waiting_pid,
   input  logic [7:0]  req_task_priority,
   input  logic [63:0] req_period,
   input  logic [63:0] req_deadline,
   input  logic [63:0] req_now,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_picked_pid,
   output logic        rsp_deadline_missed,
   output logic        rsp_boosted,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   edfts_pkg::edfts_cmd_type  cmd;
   edfts_pkg::edfts_stat_type stat;

   edfts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   edfts_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_kind            (req_kind),
      .req_pid             (req_pid),
      .req_waiting_pid     (req_waiting_pid),
      .req_task_priority   (req_task_priority),
      .req_period          (req_period),
      .req_deadline        (req_deadline),
      .req_now             (req_now),
      .rsp_status          (rsp_status),
      .rsp_picked_pid      (rsp_picked_pid),
      .rsp_deadline_missed (rsp_deadline_missed),
      .rsp_boosted         (rsp_boosted)
   );

endmodule
